// ===== rtl/pit_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the bucket hash for the pool/object identity table.
// No dependencies; used by pit_engine and pool_object_identity_table_unit.
package pit_pkg;

    localparam int POOL_BUCKET_BITS_DEF = 8;
    localparam int OBJ_BUCKET_BITS_DEF  = 12;
    localparam int POOL_ENTRIES_DEF     = 512;
    localparam int OBJ_ENTRIES_DEF      = 8192;

    localparam logic [31:0] HASH_MUL = 32'd2654435761;

    typedef enum logic [2:0] {
        FN_POOL_INSERT  = 3'd0,
        FN_POOL_DESTROY = 3'd1,
        FN_POOL_RESET   = 3'd2,
        FN_OBJ_INSERT   = 3'd3,
        FN_OBJ_FREE     = 3'd4,
        FN_POOL_LOOKUP  = 3'd5
    } pit_func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } pit_status_t;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_PHASH, S_PHEAD_RD, S_PHEAD, S_PWALK, S_PMISS, S_PALLOC,
        S_PFOUND, S_OHASH, S_OHEAD_RD, S_OHEAD, S_OWALK, S_OALLOC, S_FOWN_RD,
        S_FOWN, S_FWALK, S_RLOAD, S_RHEAD_RD, S_RHEAD, S_RWALK, S_RFREE, S_PEND,
        S_PUNLINK, S_DONE
    } pit_state_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] pool_id;
        logic [31:0] obj_id;
        logic [63:0] handle;
    } pit_req_t;

    typedef struct packed {
        logic [31:0] full_events;
        logic [13:0] objects_in_use;
        logic [9:0]  pools_in_use;
        logic [13:0] dropped_objects;
        logic [63:0] handle_out;
        logic [1:0]  status;
    } pit_rsp_t;

    // Multiplicative hash, low 32 bits of the product.
    function automatic logic [31:0] hash32(input logic [31:0] id);
        logic [63:0] prod;
        prod = 64'(id) * 64'(HASH_MUL);
        return prod[31:0];
    endfunction

endpackage

// ===== rtl/pool_object_identity_table_unit.sv =====
`timescale 1ns / 1ps
// Top level of the pool/object identity table: stream ports and result register.
// Depends on pit_pkg and pit_engine.
//
//  channel | direction | tdata                                   | tuser
//  s_axis  | in        | pool_id, obj_id, handle (128 bits)      | func (3 bits)
//  m_axis  | out       | status .. full_events (136 bits)        | -
//
// After reset the bucket heads are swept to null; s_axis_tready stays low meanwhile.
// Each transaction is handled alone by a sequencer around the entry RAMs (registered
// read data): a pool lookup or insert walks the pool hash chain, object insert and free
// then read the object bucket, object free also walks the hash chain and owner list, and
// a pool destroy or reset handles each object it drops plus its bucket-chain walk.
// The sequencer returns to idle between transactions.
// The result register lets the next transaction start while m_axis is stalled.
module pool_object_identity_table_unit #(
    parameter int POOL_BUCKET_BITS = pit_pkg::POOL_BUCKET_BITS_DEF,
    parameter int OBJ_BUCKET_BITS  = pit_pkg::OBJ_BUCKET_BITS_DEF,
    parameter int POOL_ENTRIES     = pit_pkg::POOL_ENTRIES_DEF,
    parameter int OBJ_ENTRIES      = pit_pkg::OBJ_ENTRIES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // pool_id[31:0], obj_id[63:32], handle[127:64]
    input  logic [2:0]   s_axis_tuser,   // func[2:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], handle_out[65:2], dropped_objects[79:66], pools_in_use[89:80],
    // objects_in_use[103:90], full_events[135:104]
    output logic [135:0] m_axis_tdata
);

    pit_pkg::pit_req_t req;
    pit_pkg::pit_rsp_t rsp;
    logic              rsp_valid, rsp_ready;
    logic              m_valid_reg, m_valid_next;
    logic [135:0]      m_data_reg, m_data_next;

    assign req.func    = s_axis_tuser;
    assign req.pool_id = s_axis_tdata[31:0];
    assign req.obj_id  = s_axis_tdata[63:32];
    assign req.handle  = s_axis_tdata[127:64];

    pit_engine #(
        .POOL_BUCKET_BITS(POOL_BUCKET_BITS),
        .OBJ_BUCKET_BITS (OBJ_BUCKET_BITS),
        .POOL_ENTRIES    (POOL_ENTRIES),
        .OBJ_ENTRIES     (OBJ_ENTRIES)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_req   (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    assign rsp_ready = !m_valid_reg || m_axis_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (rsp_valid && rsp_ready) begin
            m_valid_next = 1'b1;
            m_data_next  = rsp;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// ===== rtl/pit_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module pit_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/pit_engine.sv =====
`timescale 1ns / 1ps
// Table sequencer: pool and object entry RAMs, bucket head RAMs, free lists, counters.
// Depends on pit_pkg and pit_ram.
module pit_engine #(
    parameter int POOL_BUCKET_BITS = pit_pkg::POOL_BUCKET_BITS_DEF,
    parameter int OBJ_BUCKET_BITS  = pit_pkg::OBJ_BUCKET_BITS_DEF,
    parameter int POOL_ENTRIES     = pit_pkg::POOL_ENTRIES_DEF,
    parameter int OBJ_ENTRIES      = pit_pkg::OBJ_ENTRIES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  pit_pkg::pit_req_t in_req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output pit_pkg::pit_rsp_t rsp
);

    localparam int PAW = $clog2(POOL_ENTRIES);
    localparam int PIW = $clog2(POOL_ENTRIES + 1);
    localparam int OAW = $clog2(OBJ_ENTRIES);
    localparam int OIW = $clog2(OBJ_ENTRIES + 1);
    localparam int PB  = 1 << POOL_BUCKET_BITS;
    localparam int OB  = 1 << OBJ_BUCKET_BITS;
    localparam int CLR_BITS = (POOL_BUCKET_BITS > OBJ_BUCKET_BITS) ?
                              POOL_BUCKET_BITS : OBJ_BUCKET_BITS;
    localparam logic [PIW-1:0] POOL_NIL = PIW'(POOL_ENTRIES);
    localparam logic [OIW-1:0] OBJ_NIL  = OIW'(OBJ_ENTRIES);

    // link doubles as the free-list pointer while an entry is free
    typedef struct packed {
        logic [31:0]    ident;
        logic [63:0]    handle;
        logic [PIW-1:0] link;
        logic [OIW-1:0] first;
    } pool_word_t;

    typedef struct packed {
        logic [31:0]    ident;
        logic [PAW-1:0] owner;
        logic [63:0]    handle;
        logic [OIW-1:0] link;
        logic [OIW-1:0] onext;
    } obj_word_t;

    // RAM ports
    logic                        p_we, pb_we, o_we, ob_we;
    logic [PAW-1:0]              p_waddr, p_raddr;
    logic [OAW-1:0]              o_waddr, o_raddr;
    logic [POOL_BUCKET_BITS-1:0] pb_waddr, pb_raddr;
    logic [OBJ_BUCKET_BITS-1:0]  ob_waddr, ob_raddr;
    pool_word_t                  p_wdata, p_rword;
    obj_word_t                   o_wdata, o_rword;
    logic [PIW-1:0]              pb_wdata, pb_rdata;
    logic [OIW-1:0]              ob_wdata, ob_rdata;
    logic [$bits(pool_word_t)-1:0] p_rdata;
    logic [$bits(obj_word_t)-1:0]  o_rdata;

    assign p_rword = pool_word_t'(p_rdata);
    assign o_rword = obj_word_t'(o_rdata);

    pit_ram #(.WIDTH($bits(pool_word_t)), .DEPTH(POOL_ENTRIES)) u_pool_ram (
        .aclk(aclk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );
    pit_ram #(.WIDTH(PIW), .DEPTH(PB)) u_pool_bucket_ram (
        .aclk(aclk), .we(pb_we), .waddr(pb_waddr), .wdata(pb_wdata),
        .raddr(pb_raddr), .rdata(pb_rdata)
    );
    pit_ram #(.WIDTH($bits(obj_word_t)), .DEPTH(OBJ_ENTRIES)) u_obj_ram (
        .aclk(aclk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
        .raddr(o_raddr), .rdata(o_rdata)
    );
    pit_ram #(.WIDTH(OIW), .DEPTH(OB)) u_obj_bucket_ram (
        .aclk(aclk), .we(ob_we), .waddr(ob_waddr), .wdata(ob_wdata),
        .raddr(ob_raddr), .rdata(ob_rdata)
    );

    // control state
    pit_pkg::pit_state_t state_reg, state_next;
    logic [CLR_BITS-1:0] clr_reg, clr_next;
    logic [PIW-1:0]      pfree_reg, pfree_next, pfresh_reg, pfresh_next;
    logic [OIW-1:0]      ofree_reg, ofree_next, ofresh_reg, ofresh_next;
    logic [PIW-1:0]      pcount_reg, pcount_next;
    logic [OIW-1:0]      ocount_reg, ocount_next;
    logic [31:0]         full_reg, full_next;

    // per-transaction working registers
    pit_pkg::pit_req_t           req_reg, req_next;
    logic [POOL_BUCKET_BITS-1:0] pbkt_reg, pbkt_next;
    logic [OBJ_BUCKET_BITS-1:0]  obkt_reg, obkt_next;
    logic [PIW-1:0]              pcur_reg, pcur_next, pprev_reg, pprev_next;
    logic [PIW-1:0]              phead_reg, phead_next;
    pool_word_t                  pword_reg, pword_next, pprev_word_reg, pprev_word_next;
    logic [OIW-1:0]              ocur_reg, ocur_next, owalk_reg, owalk_next;
    logic [OIW-1:0]              ohead_reg, ohead_next;
    obj_word_t                   eword_reg, eword_next;
    logic [OIW-1:0]              dropped_reg, dropped_next;
    logic [1:0]                  status_reg, status_next;
    logic [63:0]                 hout_reg, hout_next;

    logic [31:0] phash, ohash, ohash_in;

    assign phash    = pit_pkg::hash32(req_reg.pool_id);
    assign ohash_in = (state_reg == pit_pkg::S_RLOAD) ? o_rword.ident : req_reg.obj_id;
    assign ohash    = pit_pkg::hash32(ohash_in);

    assign in_ready  = (state_reg == pit_pkg::S_IDLE);
    assign rsp_valid = (state_reg == pit_pkg::S_DONE);
    assign rsp.status          = status_reg;
    assign rsp.handle_out      = hout_reg;
    assign rsp.dropped_objects = 14'(dropped_reg);
    assign rsp.pools_in_use    = 10'(pcount_reg);
    assign rsp.objects_in_use  = 14'(ocount_reg);
    assign rsp.full_events     = full_reg;

    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        pfree_next      = pfree_reg;
        pfresh_next     = pfresh_reg;
        ofree_next      = ofree_reg;
        ofresh_next     = ofresh_reg;
        pcount_next     = pcount_reg;
        ocount_next     = ocount_reg;
        full_next       = full_reg;
        req_next        = req_reg;
        pbkt_next       = pbkt_reg;
        obkt_next       = obkt_reg;
        pcur_next       = pcur_reg;
        pprev_next      = pprev_reg;
        phead_next      = phead_reg;
        pword_next      = pword_reg;
        pprev_word_next = pprev_word_reg;
        ocur_next       = ocur_reg;
        owalk_next      = owalk_reg;
        ohead_next      = ohead_reg;
        eword_next      = eword_reg;
        dropped_next    = dropped_reg;
        status_next     = status_reg;
        hout_next       = hout_reg;

        p_we = 1'b0;  p_waddr = pcur_reg[PAW-1:0];  p_wdata = pword_reg;
        p_raddr = pcur_reg[PAW-1:0];
        pb_we = 1'b0; pb_waddr = pbkt_reg; pb_wdata = POOL_NIL; pb_raddr = pbkt_reg;
        o_we = 1'b0;  o_waddr = ocur_reg[OAW-1:0];  o_wdata = eword_reg;
        o_raddr = ocur_reg[OAW-1:0];
        ob_we = 1'b0; ob_waddr = obkt_reg; ob_wdata = OBJ_NIL; ob_raddr = obkt_reg;

        unique case (state_reg)
            pit_pkg::S_CLEAR: begin
                // sweep all bucket heads to null after reset
                pb_we    = ({1'b0, clr_reg} < (CLR_BITS + 1)'(PB));
                pb_waddr = clr_reg[POOL_BUCKET_BITS-1:0];
                ob_we    = ({1'b0, clr_reg} < (CLR_BITS + 1)'(OB));
                ob_waddr = clr_reg[OBJ_BUCKET_BITS-1:0];
                clr_next = clr_reg + 1'b1;
                if (&clr_reg) begin
                    state_next = pit_pkg::S_IDLE;
                end
            end
            pit_pkg::S_IDLE: begin
                if (in_valid) begin
                    req_next   = in_req;
                    state_next = pit_pkg::S_PHASH;
                end
            end
            pit_pkg::S_PHASH: begin
                pbkt_next    = phash[31 -: POOL_BUCKET_BITS];
                dropped_next = '0;
                hout_next    = '0;
                status_next  = pit_pkg::ST_NOT_FOUND;
                if (req_reg.func > pit_pkg::FN_POOL_LOOKUP || req_reg.pool_id == '0) begin
                    state_next = pit_pkg::S_DONE;
                end else begin
                    state_next = pit_pkg::S_PHEAD_RD;
                end
            end
            pit_pkg::S_PHEAD_RD: begin
                state_next = pit_pkg::S_PHEAD;
            end
            pit_pkg::S_PHEAD: begin
                phead_next = pb_rdata;
                pprev_next = POOL_NIL;
                pcur_next  = pb_rdata;
                p_raddr    = pb_rdata[PAW-1:0];
                state_next = (pb_rdata == POOL_NIL) ? pit_pkg::S_PMISS : pit_pkg::S_PWALK;
            end
            pit_pkg::S_PWALK: begin
                if (p_rword.ident == req_reg.pool_id) begin
                    pword_next = p_rword;
                    state_next = pit_pkg::S_PFOUND;
                end else begin
                    pprev_next      = pcur_reg;
                    pprev_word_next = p_rword;
                    pcur_next       = p_rword.link;
                    p_raddr         = p_rword.link[PAW-1:0];
                    if (p_rword.link == POOL_NIL) begin
                        state_next = pit_pkg::S_PMISS;
                    end
                end
            end
            pit_pkg::S_PMISS: begin
                p_raddr = pfree_reg[PAW-1:0];
                if (req_reg.func != pit_pkg::FN_POOL_INSERT) begin
                    state_next = pit_pkg::S_DONE;
                end else if (pfree_reg == POOL_NIL) begin
                    if (full_reg != '1) full_next = full_reg + 1'b1;
                    status_next = pit_pkg::ST_FULL;
                    state_next  = pit_pkg::S_DONE;
                end else begin
                    state_next = pit_pkg::S_PALLOC;
                end
            end
            pit_pkg::S_PALLOC: begin
                p_we           = 1'b1;
                p_waddr        = pfree_reg[PAW-1:0];
                p_wdata.ident  = req_reg.pool_id;
                p_wdata.handle = req_reg.handle;
                p_wdata.link   = phead_reg;
                p_wdata.first  = OBJ_NIL;
                pb_we          = 1'b1;
                pb_wdata       = pfree_reg;
                // entries past the fresh mark were never written: their link is index + 1
                if (pfree_reg == pfresh_reg) begin
                    pfree_next  = pfree_reg + 1'b1;
                    pfresh_next = pfresh_reg + 1'b1;
                end else begin
                    pfree_next = p_rword.link;
                end
                pcount_next = pcount_reg + 1'b1;
                status_next = pit_pkg::ST_OK;
                hout_next   = req_reg.handle;
                state_next  = pit_pkg::S_DONE;
            end
            pit_pkg::S_PFOUND: begin
                o_raddr = pword_reg.first[OAW-1:0];
                case (req_reg.func)
                    pit_pkg::FN_POOL_INSERT, pit_pkg::FN_POOL_LOOKUP: begin
                        hout_next   = pword_reg.handle;
                        status_next = pit_pkg::ST_OK;
                        state_next  = pit_pkg::S_DONE;
                    end
                    pit_pkg::FN_POOL_DESTROY, pit_pkg::FN_POOL_RESET: begin
                        hout_next  = pword_reg.handle;
                        ocur_next  = pword_reg.first;
                        state_next = (pword_reg.first == OBJ_NIL) ? pit_pkg::S_PEND :
                                                                    pit_pkg::S_RLOAD;
                    end
                    pit_pkg::FN_OBJ_INSERT: begin
                        if (ofree_reg == OBJ_NIL) begin
                            if (full_reg != '1) full_next = full_reg + 1'b1;
                            status_next = pit_pkg::ST_FULL;
                            state_next  = pit_pkg::S_DONE;
                        end else begin
                            state_next = pit_pkg::S_OHASH;
                        end
                    end
                    pit_pkg::FN_OBJ_FREE: begin
                        state_next = pit_pkg::S_OHASH;
                    end
                    default: begin
                        state_next = pit_pkg::S_DONE;
                    end
                endcase
            end
            pit_pkg::S_OHASH: begin
                obkt_next  = ohash[31 -: OBJ_BUCKET_BITS];
                state_next = pit_pkg::S_OHEAD_RD;
            end
            pit_pkg::S_OHEAD_RD: begin
                state_next = pit_pkg::S_OHEAD;
            end
            pit_pkg::S_OHEAD: begin
                if (req_reg.func == pit_pkg::FN_OBJ_INSERT) begin
                    ohead_next = ob_rdata;
                    o_raddr    = ofree_reg[OAW-1:0];
                    state_next = pit_pkg::S_OALLOC;
                end else begin
                    ocur_next  = ob_rdata;
                    o_raddr    = ob_rdata[OAW-1:0];
                    state_next = (ob_rdata == OBJ_NIL) ? pit_pkg::S_DONE : pit_pkg::S_OWALK;
                end
            end
            pit_pkg::S_OWALK: begin
                if (o_rword.ident == req_reg.obj_id) begin
                    eword_next = o_rword;
                    state_next = pit_pkg::S_FOWN_RD;
                end else begin
                    ocur_next = o_rword.link;
                    o_raddr   = o_rword.link[OAW-1:0];
                    if (o_rword.link == OBJ_NIL) begin
                        state_next = pit_pkg::S_DONE;
                    end
                end
            end
            pit_pkg::S_OALLOC: begin
                o_we           = 1'b1;
                o_waddr        = ofree_reg[OAW-1:0];
                o_wdata.ident  = req_reg.obj_id;
                o_wdata.owner  = pcur_reg[PAW-1:0];
                o_wdata.handle = req_reg.handle;
                o_wdata.link   = ohead_reg;
                o_wdata.onext  = pword_reg.first;
                ob_we          = 1'b1;
                ob_wdata       = ofree_reg;
                p_we           = 1'b1;
                p_wdata.first  = ofree_reg;
                if (ofree_reg == ofresh_reg) begin
                    ofree_next  = ofree_reg + 1'b1;
                    ofresh_next = ofresh_reg + 1'b1;
                end else begin
                    ofree_next = o_rword.link;
                end
                ocount_next = ocount_reg + 1'b1;
                status_next = pit_pkg::ST_OK;
                hout_next   = req_reg.handle;
                state_next  = pit_pkg::S_DONE;
            end
            pit_pkg::S_FOWN_RD: begin
                p_raddr    = eword_reg.owner;
                state_next = pit_pkg::S_FOWN;
            end
            pit_pkg::S_FOWN: begin
                // take the object out of its owner's list
                if (p_rword.first == ocur_reg) begin
                    p_we          = 1'b1;
                    p_waddr       = eword_reg.owner;
                    p_wdata       = p_rword;
                    p_wdata.first = eword_reg.onext;
                    state_next    = pit_pkg::S_RHEAD_RD;
                end else begin
                    owalk_next = p_rword.first;
                    o_raddr    = p_rword.first[OAW-1:0];
                    state_next = pit_pkg::S_FWALK;
                end
            end
            pit_pkg::S_FWALK: begin
                if (o_rword.onext == ocur_reg) begin
                    o_we          = 1'b1;
                    o_waddr       = owalk_reg[OAW-1:0];
                    o_wdata       = o_rword;
                    o_wdata.onext = eword_reg.onext;
                    state_next    = pit_pkg::S_RHEAD_RD;
                end else begin
                    owalk_next = o_rword.onext;
                    o_raddr    = o_rword.onext[OAW-1:0];
                end
            end
            pit_pkg::S_RLOAD: begin
                eword_next = o_rword;
                obkt_next  = ohash[31 -: OBJ_BUCKET_BITS];
                state_next = pit_pkg::S_RHEAD_RD;
            end
            pit_pkg::S_RHEAD_RD: begin
                state_next = pit_pkg::S_RHEAD;
            end
            pit_pkg::S_RHEAD: begin
                // take the object out of its bucket chain
                if (ob_rdata == ocur_reg) begin
                    ob_we      = 1'b1;
                    ob_wdata   = eword_reg.link;
                    state_next = pit_pkg::S_RFREE;
                end else begin
                    owalk_next = ob_rdata;
                    o_raddr    = ob_rdata[OAW-1:0];
                    state_next = pit_pkg::S_RWALK;
                end
            end
            pit_pkg::S_RWALK: begin
                if (o_rword.link == ocur_reg) begin
                    o_we         = 1'b1;
                    o_waddr      = owalk_reg[OAW-1:0];
                    o_wdata      = o_rword;
                    o_wdata.link = eword_reg.link;
                    state_next   = pit_pkg::S_RFREE;
                end else begin
                    owalk_next = o_rword.link;
                    o_raddr    = o_rword.link[OAW-1:0];
                end
            end
            pit_pkg::S_RFREE: begin
                o_we           = 1'b1;
                o_wdata.ident  = '0;
                o_wdata.handle = '0;
                o_wdata.link   = ofree_reg;
                ofree_next     = ocur_reg;
                if (ocount_reg != '0) ocount_next = ocount_reg - 1'b1;
                dropped_next   = dropped_reg + 1'b1;
                o_raddr        = eword_reg.onext[OAW-1:0];
                if (req_reg.func == pit_pkg::FN_OBJ_FREE) begin
                    status_next = pit_pkg::ST_OK;
                    hout_next   = eword_reg.handle;
                    state_next  = pit_pkg::S_DONE;
                end else begin
                    ocur_next  = eword_reg.onext;
                    state_next = (eword_reg.onext == OBJ_NIL) ? pit_pkg::S_PEND :
                                                                pit_pkg::S_RLOAD;
                end
            end
            pit_pkg::S_PEND: begin
                p_we          = 1'b1;
                p_wdata.first = OBJ_NIL;
                status_next   = pit_pkg::ST_OK;
                state_next    = pit_pkg::S_DONE;
                if (req_reg.func == pit_pkg::FN_POOL_DESTROY) begin
                    p_wdata.ident  = '0;
                    p_wdata.handle = '0;
                    p_wdata.link   = pfree_reg;
                    pfree_next     = pcur_reg;
                    if (pcount_reg != '0) pcount_next = pcount_reg - 1'b1;
                    if (pprev_reg == POOL_NIL) begin
                        pb_we    = 1'b1;
                        pb_wdata = pword_reg.link;
                    end else begin
                        state_next = pit_pkg::S_PUNLINK;
                    end
                end
            end
            pit_pkg::S_PUNLINK: begin
                p_we         = 1'b1;
                p_waddr      = pprev_reg[PAW-1:0];
                p_wdata      = pprev_word_reg;
                p_wdata.link = pword_reg.link;
                state_next   = pit_pkg::S_DONE;
            end
            pit_pkg::S_DONE: begin
                if (rsp_ready) begin
                    state_next = pit_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = pit_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= pit_pkg::S_CLEAR;
            clr_reg    <= '0;
            pfree_reg  <= '0;
            pfresh_reg <= '0;
            ofree_reg  <= '0;
            ofresh_reg <= '0;
            pcount_reg <= '0;
            ocount_reg <= '0;
            full_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            pfree_reg  <= pfree_next;
            pfresh_reg <= pfresh_next;
            ofree_reg  <= ofree_next;
            ofresh_reg <= ofresh_next;
            pcount_reg <= pcount_next;
            ocount_reg <= ocount_next;
            full_reg   <= full_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        pbkt_reg       <= pbkt_next;
        obkt_reg       <= obkt_next;
        pcur_reg       <= pcur_next;
        pprev_reg      <= pprev_next;
        phead_reg      <= phead_next;
        pword_reg      <= pword_next;
        pprev_word_reg <= pprev_word_next;
        ocur_reg       <= ocur_next;
        owalk_reg      <= owalk_next;
        ohead_reg      <= ohead_next;
        eword_reg      <= eword_next;
        dropped_reg    <= dropped_next;
        status_reg     <= status_next;
        hout_reg       <= hout_next;
    end

endmodule
